/* design/bte_pkg.sv */
// Shared types and constants for the bag table engine.
// Used by bte_ctrl, bte_dp and bag_table_engine_core; no dependencies.
package bte_pkg;

    // Storage geometry
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Request kinds as they arrive on the kind port
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INSERT,
        DP_CLEAR,
        DP_SCAN,
        DP_HIT,
        DP_MISS,
        DP_BEGIN_SHIFT,
        DP_SHIFT,
        DP_DEL_DONE
    } dp_op_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic hit;        // compare stage holds an equal valid entry
        logic pass_end;   // scan or shift pass ran past the last entry
        logic is_delete;  // current word is a delete
    } dp_status_t;

endpackage

/* design/bte_dp.sv */
// Datapath of the bag table engine: entry memory, fill count, scan/shift
// counter and result registers. Depends on bte_pkg.
module bte_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bte_pkg::dp_op_t       op,
    input  logic [1:0]            kind,
    input  logic signed [31:0]    value,
    output bte_pkg::dp_status_t   status,
    output logic                  found,
    output logic [6:0]            position,
    output logic [7:0]            fill_count,
    output logic                  is_empty_flag,
    output logic                  dropped
);
    import bte_pkg::*;

    // Entry memory, one write and one registered read per cycle
    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              rvalid_reg;
    logic [ADDR_W-1:0] cmp_idx_reg;
    logic [DATA_W-1:0] value_reg;
    logic              del_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic              dropped_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              not_full;

    assign not_full = (fill_reg < CNT_W'(CAPACITY));
    assign rd_addr  = idx_reg[ADDR_W-1:0];

    // Write port: append on insert, move down one slot during shift
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[ADDR_W-1:0];
        wr_data = value;
        case (op)
            DP_INSERT:
            begin
                wr_en   = not_full;
                wr_addr = fill_reg[ADDR_W-1:0];
                wr_data = value;
            end
            DP_SHIFT:
            begin
                wr_en   = rvalid_reg;
                wr_addr = cmp_idx_reg - ADDR_W'(1);
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Status toward the controller
    assign status.hit       = rvalid_reg && (rdata_reg == value_reg);
    assign status.pass_end  = !rvalid_reg && (idx_reg >= fill_reg);
    assign status.is_delete = del_reg;

    // Counters, fill and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            idx_reg     <= '0;
            rvalid_reg  <= 1'b0;
            del_reg     <= 1'b0;
            found_reg   <= 1'b0;
            pos_reg     <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            case (op)
                DP_LOAD:
                begin
                    del_reg    <= (kind == KIND_DELETE);
                    idx_reg    <= '0;
                    rvalid_reg <= 1'b0;
                end
                DP_INSERT:
                begin
                    if (not_full)
                    begin
                        fill_reg <= fill_reg + CNT_W'(1);
                    end
                    dropped_reg <= !not_full;
                    found_reg   <= 1'b0;
                    pos_reg     <= '0;
                end
                DP_CLEAR:
                begin
                    fill_reg    <= '0;
                    dropped_reg <= 1'b0;
                    found_reg   <= 1'b0;
                    pos_reg     <= '0;
                end
                DP_SCAN, DP_SHIFT:
                begin
                    idx_reg    <= idx_reg + CNT_W'(1);
                    rvalid_reg <= (idx_reg < fill_reg);
                end
                DP_HIT:
                begin
                    found_reg   <= 1'b1;
                    pos_reg     <= cmp_idx_reg;
                    dropped_reg <= 1'b0;
                end
                DP_MISS:
                begin
                    found_reg   <= 1'b0;
                    pos_reg     <= '0;
                    dropped_reg <= 1'b0;
                end
                DP_BEGIN_SHIFT:
                begin
                    found_reg   <= 1'b1;
                    pos_reg     <= cmp_idx_reg;
                    dropped_reg <= 1'b0;
                    idx_reg     <= CNT_W'(cmp_idx_reg) + CNT_W'(1);
                    rvalid_reg  <= 1'b0;
                end
                DP_DEL_DONE:
                begin
                    fill_reg <= fill_reg - CNT_W'(1);
                end
                default:
                begin
                    fill_reg <= fill_reg;
                end
            endcase
        end
    end

    // Payload registers without reset
    always_ff @(posedge clk)
    begin
        if (op == DP_LOAD)
        begin
            value_reg <= value;
        end
        if (op == DP_SCAN || op == DP_SHIFT)
        begin
            cmp_idx_reg <= idx_reg[ADDR_W-1:0];
        end
    end

    // Result word
    assign found         = found_reg;
    assign position      = 7'(pos_reg);
    assign fill_count    = 8'(fill_reg);
    assign is_empty_flag = (fill_reg == '0);
    assign dropped       = dropped_reg;

endmodule

/* design/bte_ctrl.sv */
// Controller state machine of the bag table engine: sequences the scan and
// shift passes and issues datapath commands. Depends on bte_pkg.
module bte_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    input  bte_pkg::dp_status_t   status,
    output bte_pkg::dp_op_t       op,
    output logic                  busy,
    output logic                  done
);
    import bte_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_DELETE || kind == KIND_SEARCH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = status.is_delete ? ST_SHIFT : ST_DONE;
                end
                else if (status.pass_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (status.pass_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        op   = DP_NOP;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (kind)
                        KIND_INSERT: op = DP_INSERT;
                        KIND_CLEAR:  op = DP_CLEAR;
                        default:     op = DP_LOAD;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    op = status.is_delete ? DP_BEGIN_SHIFT : DP_HIT;
                end
                else if (status.pass_end)
                begin
                    op = DP_MISS;
                end
                else
                begin
                    op = DP_SCAN;
                end
            end
            ST_SHIFT:
            begin
                op = status.pass_end ? DP_DEL_DONE : DP_SHIFT;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                op = DP_NOP;
            end
        endcase
    end

endmodule

/* design/bag_table_engine_core.sv */
// Top level of the bag table engine: a bounded multiset of 32-bit values.
// Instantiates bte_ctrl and bte_dp; depends on bte_pkg.
//
// A word is taken when start is high and busy is low. Its result is on the
// result ports for one cycle with done high, and the receiver cannot stall
// it. busy stays high from the accepting edge through the result cycle, so
// the next word can be taken once the controller is back in idle after
// done. Insert and clear go from idle straight to the result state. Search
// and delete scan the entry memory one entry per cycle through its
// registered read port, stopping at the first match; a miss runs past the
// last entry. A delete that hits then moves each later entry down one slot,
// one per cycle on the same port, so it passes every entry wherever the
// match sits: those before it in the scan, those after it in the shift.
// The worst case is a delete in a full bag.
module bag_table_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic signed [31:0] value,
    output logic               done,
    output logic               found,
    output logic [6:0]         position,
    output logic [7:0]         fill_count,
    output logic               is_empty_flag,
    output logic               dropped
);
    import bte_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    bte_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .op     (op),
        .busy   (busy),
        .done   (done)
    );

    bte_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .kind          (kind),
        .value         (value),
        .status        (status),
        .found         (found),
        .position      (position),
        .fill_count    (fill_count),
        .is_empty_flag (is_empty_flag),
        .dropped       (dropped)
    );

endmodule

/* tb/sv/tb_bag_table_engine_core.sv */
// Self-checking testbench for bag_table_engine_core: a built-in bag model predicts every result.
// Depends on bte_pkg (kind codes, CAPACITY) and the bag_table_engine_core RTL.
`timescale 1ns / 100ps

module tb_bag_table_engine_core;

    import bte_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_GAP     = 40;

    // Expected content of one result word
    typedef struct packed {
        logic       found;
        logic [6:0] position;
        logic [7:0] fill_count;
        logic       is_empty_flag;
        logic       dropped;
    } bag_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         kind = KIND_INSERT;
    logic signed [31:0] value = '0;
    logic               busy;
    logic               done;
    logic               found;
    logic [6:0]         position;
    logic [7:0]         fill_count;
    logic               is_empty_flag;
    logic               dropped;

    // Bag model: entries in arrival order plus fill count
    logic [31:0]  bag_mem [CAPACITY];
    int           bag_fill = 0;
    bag_result_t  bag_results_due [$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           sender_idle_pct = 0;

    bag_table_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .value         (value),
        .done          (done),
        .found         (found),
        .position      (position),
        .fill_count    (fill_count),
        .is_empty_flag (is_empty_flag),
        .dropped       (dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_bag_table_engine_core NOT OK");
            $finish;
        end
    end

    // Apply one request to the bag model and return the result it should give
    function automatic bag_result_t predict_bag_op(input logic [1:0] k, input logic [31:0] v);
        bag_result_t r;
        bit          hit;
        int          idx;
        r   = '0;
        hit = 1'b0;
        idx = 0;
        if (k == KIND_DELETE || k == KIND_SEARCH)
        begin
            for (int i = 0; i < bag_fill; i++)
                if (!hit && bag_mem[i] == v)
                begin
                    hit = 1'b1;
                    idx = i;
                end
        end
        case (k)
            KIND_INSERT:
            begin
                if (bag_fill < CAPACITY)
                begin
                    bag_mem[bag_fill] = v;
                    bag_fill++;
                end
                else
                    r.dropped = 1'b1;
            end
            KIND_DELETE:
            begin
                // close the gap, keeping arrival order
                if (hit)
                begin
                    for (int j = idx; j + 1 < bag_fill; j++)
                        bag_mem[j] = bag_mem[j + 1];
                    bag_fill--;
                end
            end
            KIND_SEARCH:
            begin
            end
            default:
                bag_fill = 0;
        endcase
        r.found         = hit;
        r.position      = idx[6:0];
        r.fill_count    = bag_fill[7:0];
        r.is_empty_flag = (bag_fill == 0);
        return r;
    endfunction

    // Value mix: stored entries, a few small values with many repeats, full random
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && bag_fill > 0)
            return bag_mem[$urandom_range(0, bag_fill - 1)];
        else if (sel < 7)
            return 32'($urandom_range(0, 6)) - 32'd3;
        else
            return $urandom;
    endfunction

    // Send one word, with random idle cycles first; start stays high on return
    task automatic send_word(input logic [1:0] k, input logic [31:0] v);
        int gap;
        gap = 0;
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct && gap < MAX_GAP)
            gap++;
        repeat (gap)
        begin
            start <= 1'b0;
            kind  <= 2'($urandom);
            value <= $urandom;
            @(posedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        bag_results_due.push_back(predict_bag_op(k, v));
    endtask

    // Drop start and hold off until every pending result is back
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (bag_results_due.size() != 0)
            @(posedge clk);
    endtask

    // Result checker: done is a one-cycle strobe
    always @(posedge clk)
    begin : check_results
        bag_result_t want;
        if (rst_n && done)
        begin
            if (bag_results_due.size() == 0)
            begin
                $error("result word with no request pending");
                error_count++;
            end
            else
            begin
                want = bag_results_due.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    error_count++;
                end
                if (position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    error_count++;
                end
                if (fill_count !== want.fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d", want.fill_count, fill_count);
                    error_count++;
                end
                if (is_empty_flag !== want.is_empty_flag)
                begin
                    $error("is_empty_flag: expected %0d, got %0d",
                           want.is_empty_flag, is_empty_flag);
                    error_count++;
                end
                if (dropped !== want.dropped)
                begin
                    $error("dropped: expected %0d, got %0d", want.dropped, dropped);
                    error_count++;
                end
            end
        end
    end

    // Extreme values, duplicates, misses, front/back deletes, clear with stale entries
    task automatic test_directed();
        send_word(KIND_SEARCH, 32'd0);
        send_word(KIND_DELETE, 32'd0);
        send_word(KIND_CLEAR, 32'hFFFF_FFFF);
        send_word(KIND_INSERT, 32'd0);
        send_word(KIND_INSERT, 32'hFFFF_FFFF);
        send_word(KIND_INSERT, 32'h7FFF_FFFF);
        send_word(KIND_INSERT, 32'h8000_0000);
        send_word(KIND_INSERT, 32'd100);
        send_word(KIND_INSERT, 32'd100);
        send_word(KIND_SEARCH, 32'd100);
        send_word(KIND_SEARCH, 32'h8000_0000);
        send_word(KIND_SEARCH, 32'd5);
        send_word(KIND_DELETE, 32'd100);
        send_word(KIND_SEARCH, 32'd100);
        send_word(KIND_DELETE, 32'd12345);
        send_word(KIND_DELETE, 32'd0);
        send_word(KIND_SEARCH, 32'hFFFF_FFFF);
        send_word(KIND_DELETE, 32'd100);
        send_word(KIND_INSERT, 32'h5555_5555);
        send_word(KIND_INSERT, 32'hAAAA_AAAA);
        send_word(KIND_CLEAR, 32'd0);
        send_word(KIND_SEARCH, 32'hFFFF_FFFF);
        send_word(KIND_INSERT, 32'd100);
        send_word(KIND_DELETE, 32'd100);
    endtask

    // Fill to capacity, refuse inserts, worst-case front delete, delete second-to-last entry
    task automatic test_full_bag();
        send_word(KIND_CLEAR, $urandom);
        while (bag_fill < CAPACITY - 1)
            send_word(KIND_INSERT, pick_value());
        send_word(KIND_INSERT, 32'h7FFF_FFFE);
        send_word(KIND_INSERT, $urandom);
        send_word(KIND_INSERT, 32'h8000_0000);
        send_word(KIND_SEARCH, 32'h7FFF_FFFE);
        send_word(KIND_DELETE, bag_mem[0]);
        send_word(KIND_INSERT, $urandom);
        send_word(KIND_DELETE, 32'h7FFF_FFFE);
        send_word(KIND_SEARCH, bag_mem[0]);
    endtask

    // Random requests, weighted toward insert so the bag grows deep
    task automatic test_random(input int count);
        int sel;
        logic [1:0] k;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                k = KIND_INSERT;
            else if (sel < 70)
                k = KIND_DELETE;
            else if (sel < 98)
                k = KIND_SEARCH;
            else
                k = KIND_CLEAR;
            send_word(k, pick_value());
        end
    endtask

    // Test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 0;
        test_directed();
        test_full_bag();
        test_random(250);
        wait_for_results();

        sender_idle_pct = 76;
        test_random(250);

        sender_idle_pct = 17;
        test_random(200);

        wait_for_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_bag_table_engine_core OK");
        else
            $display("tb_bag_table_engine_core NOT OK");
        $finish;
    end

endmodule
